// ===== design/mksm_pkg.sv =====
// shared constants and register codes for the multi-keyword stream matcher
package mksm_pkg;

	localparam int KEYWORD_SLOTS_DEF   = 4;
	localparam int MAX_KEYWORD_LEN_DEF = 8;

	// fixed field widths
	localparam int CHAR_W     = 8;
	localparam int LEN_W      = 4;
	localparam int MASK_W     = 4;
	localparam int CFG_DATA_W = 64;
	localparam int CFG_IDX_W  = 3;

	// register indexes on the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_KEYWORD_BASE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LENGTHS      = 3'd4;

	typedef logic [CHAR_W-1:0] char_t;
	typedef logic [LEN_W-1:0]  len_t;
	typedef logic [MASK_W-1:0] mask_t;

endpackage

// ===== design/mksm_cfg_regs.sv =====
// configuration registers: keyword characters and clamped slot lengths
module mksm_cfg_regs #(
	parameter int KEYWORD_SLOTS   = mksm_pkg::KEYWORD_SLOTS_DEF,
	parameter int MAX_KEYWORD_LEN = mksm_pkg::MAX_KEYWORD_LEN_DEF
) (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  logic                                        cfg_we,
	input  logic [mksm_pkg::CFG_IDX_W-1:0]              cfg_index,
	input  logic [mksm_pkg::CFG_DATA_W-1:0]             cfg_wdata,
	output logic [MAX_KEYWORD_LEN*mksm_pkg::CHAR_W-1:0] kw_chars [KEYWORD_SLOTS],
	output mksm_pkg::len_t                              kw_len   [KEYWORD_SLOTS]
);
	import mksm_pkg::*;

	localparam int KW_W = MAX_KEYWORD_LEN * CHAR_W;

	logic [KW_W-1:0] keyword_q [KEYWORD_SLOTS];
	len_t            length_q  [KEYWORD_SLOTS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < KEYWORD_SLOTS; s++) begin
				keyword_q[s] <= '0;
				length_q[s]  <= '0;
			end
		end else if (cfg_we) begin
			for (int s = 0; s < KEYWORD_SLOTS; s++) begin
				if (cfg_index == REG_KEYWORD_BASE + CFG_IDX_W'(s)) begin
					keyword_q[s] <= cfg_wdata[KW_W-1:0];
				end
				if (cfg_index == REG_LENGTHS) begin
					length_q[s] <= cfg_wdata[s*LEN_W +: LEN_W];
				end
			end
		end
	end

	// lengths above the longest supported keyword count as the longest
	always_comb begin
		for (int s = 0; s < KEYWORD_SLOTS; s++) begin
			kw_chars[s] = keyword_q[s];
			kw_len[s]   = (length_q[s] > LEN_W'(MAX_KEYWORD_LEN)) ?
				LEN_W'(MAX_KEYWORD_LEN) : length_q[s];
		end
	end

endmodule

// ===== design/mksm_slot.sv =====
// one keyword slot: progress counter and next-character compare
module mksm_slot #(
	parameter int MAX_KEYWORD_LEN = mksm_pkg::MAX_KEYWORD_LEN_DEF
) (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  logic                                        advance,
	input  mksm_pkg::char_t                             ch,
	input  logic [MAX_KEYWORD_LEN*mksm_pkg::CHAR_W-1:0] kw_chars,
	input  mksm_pkg::len_t                              kw_len,
	output logic                                        hit
);
	import mksm_pkg::*;

	localparam int PROG_W = (MAX_KEYWORD_LEN > 1) ? $clog2(MAX_KEYWORD_LEN) : 1;

	logic [PROG_W-1:0] progress_q;
	char_t             kw [MAX_KEYWORD_LEN];
	len_t              prog_ext;
	len_t              step;
	len_t              nxt;

	always_comb begin
		for (int i = 0; i < MAX_KEYWORD_LEN; i++) begin
			kw[i] = kw_chars[i*CHAR_W +: CHAR_W];
		end
	end

	// progress stays below the longest keyword length, so the index is always in range when read
	always_comb begin
		prog_ext = LEN_W'(progress_q);
		step     = '0;
		nxt      = '0;
		hit      = 1'b0;
		if (kw_len != '0 && ch != '0) begin
			if (prog_ext < kw_len && ch == kw[progress_q]) begin
				step = prog_ext + LEN_W'(1);
			end else begin
				// mismatch: start again, this char may open the keyword
				step = (ch == kw[0]) ? LEN_W'(1) : '0;
			end
			if (step >= kw_len) begin
				hit = 1'b1;
			end else begin
				nxt = step;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			progress_q <= '0;
		end else if (advance) begin
			progress_q <= nxt[PROG_W-1:0];
		end
	end

endmodule

// ===== design/multi_keyword_stream_matcher_top.sv =====
// top level of the multi-keyword stream matcher
//
// usage
// - input channel: one typed character per beat on typed_char with in_valid and
//   in_stall; character 0 means no character and clears all slot progress
// - output channel: one match_mask beat per input beat with out_valid and
//   out_stall; bit s is set when slot s finished its keyword on that character
// - configuration: cfg_we writes register cfg_index (0..3 keyword characters,
//   first character in the low byte; 4 packed 4-bit lengths); other indexes
//   are ignored; write only while the block is idle
// - an accepted input beat goes to the input register, and its result to the
//   output register after it; throughput one character per cycle while
//   out_stall is low, set by the single compare-and-count pass per slot
//   between the input and result registers
// - a stalled result holds; the input register still takes one more beat,
//   and in_stall rises only once that register is full as well
// - reset clears the keywords, lengths (all slots disabled), slot progress
//   and the valid flags of both pipeline registers; no clearing pass is needed
module multi_keyword_stream_matcher_top #(
	parameter int KEYWORD_SLOTS   = mksm_pkg::KEYWORD_SLOTS_DEF,
	parameter int MAX_KEYWORD_LEN = mksm_pkg::MAX_KEYWORD_LEN_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// configuration port
	input  logic                            cfg_we,
	input  logic [mksm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [mksm_pkg::CFG_DATA_W-1:0] cfg_wdata,
	// character input
	input  logic                            in_valid,
	output logic                            in_stall,
	input  mksm_pkg::char_t                 typed_char,
	// match result
	output logic                            out_valid,
	input  logic                            out_stall,
	output mksm_pkg::mask_t                 match_mask
);
	import mksm_pkg::*;

	localparam int KW_W = MAX_KEYWORD_LEN * CHAR_W;

	logic [KW_W-1:0] kw_chars [KEYWORD_SLOTS];
	len_t            kw_len   [KEYWORD_SLOTS];

	// stage 1: input register
	logic  valid_s1;
	char_t char_s1;
	// stage 2: result register
	logic  valid_s2;
	mask_t mask_s2;

	logic  advance;
	mask_t hits;

	mksm_cfg_regs #(
		.KEYWORD_SLOTS   (KEYWORD_SLOTS),
		.MAX_KEYWORD_LEN (MAX_KEYWORD_LEN)
	) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.kw_chars  (kw_chars),
		.kw_len    (kw_len)
	);

	// the stage-1 beat moves on when the result register is empty or draining
	assign advance  = valid_s1 && (!valid_s2 || !out_stall);
	// input register full and unable to move on
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			char_s1 <= typed_char;
		end
	end

	// all slots compare the same character in parallel
	for (genvar s = 0; s < MASK_W; s++) begin : g_slot
		if (s < KEYWORD_SLOTS) begin : g_used
			mksm_slot #(
				.MAX_KEYWORD_LEN (MAX_KEYWORD_LEN)
			) u_slot (
				.clk      (clk),
				.arst_n   (arst_n),
				.advance  (advance),
				.ch       (char_s1),
				.kw_chars (kw_chars[s]),
				.kw_len   (kw_len[s]),
				.hit      (hits[s])
			);
		end else begin : g_unused
			// slots beyond the built ones never match
			assign hits[s] = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			mask_s2 <= hits;
		end
	end

	assign out_valid  = valid_s2;
	assign match_mask = mask_s2;

	// a beat that moves on always lands in the result register
	a_advance_fills: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> valid_s2)
		else $error("result register empty after a beat moved on");

	// stalling the input only happens with a full input register behind a held result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && valid_s2 && out_stall))
		else $error("input stalled without a held result");

	// no character never completes a keyword
	a_null_char: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && char_s1 == '0) |=> (match_mask == '0))
		else $error("match reported on a null character");

	// a held result is not overwritten
	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && out_stall) |-> !advance)
		else $error("held result overwritten");

endmodule

// ===== test/multi_keyword_stream_matcher_top_test.sv =====
`timescale 1ns / 100ps
// self-checking testbench for the multi-keyword stream matcher top level
module multi_keyword_stream_matcher_top_test;
	import mksm_pkg::*;

	localparam int HOLD_CYCLES  = 40;      // long receiver hold-off to fill the pipeline
	localparam int CYCLE_LIMIT  = 200000;  // generous ceiling on the whole run
	localparam int DRAIN_CYCLES = 4;       // margin after the last owed mask has come out
	localparam int PHASES       = 8;
	localparam int PHASE_ITEMS  = 100;

	typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
	typedef logic [CFG_DATA_W-1:0] cfg_word_t;

	// first register index that the block is meant to ignore
	localparam cfg_idx_t REG_IGNORED_FIRST = REG_LENGTHS + 3'd1;

	localparam char_t NO_CHAR  = 8'h00;
	localparam char_t CH_A     = 8'h61;
	localparam char_t CH_B     = 8'h62;
	localparam char_t CH_ALL   = 8'hFF;
	localparam char_t CH_TOP   = 8'h80;

	// keeps its own copy of keywords, lengths and slot progress, and holds the
	// masks still owed by the block in arrival order
	class match_tracker;
		cfg_word_t keywords [4];
		logic [15:0] lengths;
		logic [3:0] progress [4];
		mask_t pending_masks [$];
		int failures;

		function new();
			for (int s = 0; s < 4; s++) begin
				keywords[s] = '0;
				progress[s] = '0;
			end
			lengths = '0;
			failures = 0;
		endfunction

		function void set_register(cfg_idx_t idx, cfg_word_t val);
			if (idx < REG_LENGTHS)
				keywords[idx - REG_KEYWORD_BASE] = val;
			else if (idx == REG_LENGTHS)
				lengths = val[15:0];
		endfunction

		// slot length with oversized fields clamped to the longest keyword
		function int slot_len(int s);
			int len;
			len = lengths[4*s +: 4];
			if (len > MAX_KEYWORD_LEN_DEF)
				len = MAX_KEYWORD_LEN_DEF;
			return len;
		endfunction

		function void take_char(char_t c);
			mask_t mask;
			int len;
			int p;
			mask = '0;
			for (int s = 0; s < KEYWORD_SLOTS_DEF; s++) begin
				len = slot_len(s);
				if (len == 0 || c == NO_CHAR) begin
					progress[s] = '0;
					continue;
				end
				p = progress[s];
				// a stale count at or past the length is treated as a miss
				if (p < len && c == keywords[s][8*p +: 8])
					p++;
				else
					p = (c == keywords[s][7:0]) ? 1 : 0;
				if (p >= len) begin
					mask[s] = 1'b1;
					p = 0;
				end
				progress[s] = p[3:0];
			end
			pending_masks.insert(pending_masks.size(), mask);
		endfunction

		function void check_mask(mask_t actual);
			mask_t wanted;
			if (pending_masks.size() == 0) begin
				$error("match_mask beat with no character pending: got %h", actual);
				failures++;
				return;
			end
			wanted = pending_masks.pop_front();
			if (actual !== wanted) begin
				$error("match_mask expected %h actual %h", wanted, actual);
				failures++;
			end
		endfunction

		function int pending();
			return pending_masks.size();
		endfunction
	endclass

	// every input starts at a known value
	logic      clk        = 1'b0;
	logic      arst_n     = 1'b0;
	logic      cfg_we     = 1'b0;
	cfg_idx_t  cfg_index  = '0;
	cfg_word_t cfg_wdata  = '0;
	logic      in_valid   = 1'b0;
	char_t     typed_char = '0;
	logic      out_stall  = 1'b0;
	logic      in_stall;
	logic      out_valid;
	mask_t     match_mask;

	match_tracker tracker = new();

	// phase controls shared by the sender, the receiver and the main sequence
	bit calm_phase   = 1'b0;  // no gaps on either side
	bit hold_request = 1'b0;  // receiver should hold off for a long stretch
	int cycles       = 0;

	multi_keyword_stream_matcher_top u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.typed_char (typed_char),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.match_mask (match_mask)
	);

	always #5 clk = ~clk;

	// watchdog: a hung handshake ends the run as a failure
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// beat monitor: values read here are the ones before this edge's updates,
	// so the handshake seen is exactly the one the block sees
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				tracker.take_char(typed_char);
			if (out_valid && !out_stall)
				tracker.check_mask(match_mask);
		end
	end

	// result receiver: draws a stall before each beat, or a long hold-off when
	// asked, so that the block backs up and raises in_stall
	initial begin
		int wait_cycles;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (hold_request) begin
				wait_cycles = HOLD_CYCLES;
				hold_request = 1'b0;
			end else begin
				wait_cycles = calm_phase ? 0 : $urandom_range(0, 6);
			end
			if (wait_cycles > 0) begin
				out_stall <= 1'b1;
				repeat (wait_cycles) @(posedge clk);
				out_stall <= 1'b0;
			end
			// stay ready until a result beat goes through
			do @(posedge clk); while (!out_valid);
		end
	end

	// offer one character, after a random gap, and hold it until taken
	task automatic send_char(input char_t c);
		int gap;
		gap = calm_phase ? 0 : $urandom_range(0, 6);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid   <= 1'b1;
		typed_char <= c;
		do @(posedge clk); while (in_stall);
	endtask

	// one register write, with cfg_we low again after it
	task automatic write_reg(input cfg_idx_t idx, input cfg_word_t val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		tracker.set_register(idx, val);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// stop offering and wait until every owed mask has come out, then let the
	// pipeline empty so that a register write cannot meet a character in flight
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (tracker.pending() > 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// keywords mostly drawn from a three-letter alphabet so that random text
	// actually completes them; now and then fully random bits
	function automatic cfg_word_t random_keyword();
		cfg_word_t w;
		if ($urandom_range(0, 5) == 0)
			return {$urandom, $urandom};
		for (int i = 0; i < 8; i++) begin
			if ($urandom_range(0, 7) == 0)
				w[8*i +: 8] = char_t'($urandom_range(0, 255));
			else
				w[8*i +: 8] = CH_A + char_t'($urandom_range(0, 2));
		end
		return w;
	endfunction

	// lengths: all clamped in the first phase, all disabled in the second,
	// then a mix of normal, zero and oversized fields; upper data bits are junk
	function automatic cfg_word_t random_lengths(int phase);
		logic [15:0] lens;
		int r;
		if (phase == 0)
			lens = 16'hFFFF;
		else if (phase == 1)
			lens = 16'h0000;
		else if ($urandom_range(0, 5) == 0)
			lens = 16'($urandom);
		else begin
			for (int s = 0; s < 4; s++) begin
				r = $urandom_range(0, 9);
				if (r == 0)
					lens[4*s +: 4] = 4'd0;
				else if (r == 1)
					lens[4*s +: 4] = 4'($urandom_range(9, 15));
				else
					lens[4*s +: 4] = 4'($urandom_range(1, 8));
			end
		end
		return {16'($urandom), $urandom, lens};
	endfunction

	// write all five registers in a rotated order, sometimes an ignored index too
	task automatic configure_phase(input int phase);
		int first;
		int k;
		first = $urandom_range(0, 4);
		for (int n = 0; n < 5; n++) begin
			k = (first + n) % 5;
			if (k < 4)
				write_reg(REG_KEYWORD_BASE + cfg_idx_t'(k), random_keyword());
			else
				write_reg(REG_LENGTHS, random_lengths(phase));
		end
		if ($urandom_range(0, 2) == 0)
			write_reg(REG_IGNORED_FIRST + cfg_idx_t'($urandom_range(0, 2)),
				{$urandom, $urandom});
	endtask

	// random text: mostly whole or partial keywords, the rest alphabet letters,
	// arbitrary bytes and the no-character code
	task automatic random_text(input int count);
		int sent;
		int kind;
		int s;
		int len;
		int n;
		sent = 0;
		while (sent < count) begin
			kind = $urandom_range(0, 9);
			if (kind <= 5) begin
				s = $urandom_range(0, 3);
				len = tracker.slot_len(s);
				if (len == 0)
					len = $urandom_range(1, MAX_KEYWORD_LEN_DEF);
				n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, len) : len;
				for (int i = 0; i < n; i++)
					send_char(tracker.keywords[s][8*i +: 8]);
				sent += n;
			end else begin
				if (kind <= 7)
					send_char(CH_A + char_t'($urandom_range(0, 2)));
				else if (kind == 8)
					send_char(char_t'($urandom_range(0, 255)));
				else
					send_char(NO_CHAR);
				sent++;
			end
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: "ab" in slot 0, all-ones in slot 1, "aab" in slot 2,
		// slot 3 disabled; a write to an ignored index must not disturb anything
		write_reg(REG_KEYWORD_BASE + 3'd0, 64'h6261);
		write_reg(REG_KEYWORD_BASE + 3'd1, '1);
		write_reg(REG_KEYWORD_BASE + 3'd2, 64'h626161);
		write_reg(REG_KEYWORD_BASE + 3'd3, '0);
		write_reg(REG_LENGTHS, 64'h0382);
		write_reg(REG_IGNORED_FIRST, '1);

		send_char(CH_A);     // plain hit on slot 0
		send_char(CH_B);
		send_char(CH_A);     // no character in the middle clears progress
		send_char(NO_CHAR);
		send_char(CH_B);
		send_char(CH_A);     // repeated first letter against "aab"
		send_char(CH_A);
		send_char(CH_A);
		send_char(CH_B);
		repeat (8) send_char(CH_ALL);  // longest keyword, top character
		send_char(CH_TOP);
		repeat (5) send_char(CH_ALL);  // leave slot 1 part way through
		settle();

		// lengths cut below the progress already made: the next character is a
		// miss that restarts on the first letter; slot 3 oversized, slot 2 off
		write_reg(REG_KEYWORD_BASE + 3'd3, '1);
		write_reg(REG_LENGTHS, 64'hF032);
		repeat (3) send_char(CH_ALL);
		settle();

		// random phases; one with a long receiver hold-off while the sender keeps
		// offering back to back, and one with no idling at all
		for (int phase = 0; phase < PHASES; phase++) begin
			configure_phase(phase);
			calm_phase = (phase == 3) || (phase == 5);
			hold_request = (phase == 3);
			random_text(PHASE_ITEMS);
			settle();
			calm_phase = 1'b0;
		end

		if (tracker.failures == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

// ===== files.f =====
design/mksm_pkg.sv
design/mksm_cfg_regs.sv
design/mksm_slot.sv
design/multi_keyword_stream_matcher_top.sv
test/multi_keyword_stream_matcher_top_test.sv
